>>> design/rida_pkg.sv
// ----------------------------------------------------------------------------
// rida_pkg
// Shared constants, codes and types of the region id allocator.
// ----------------------------------------------------------------------------
package rida_pkg;

  // Table geometry.
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned SLOT_W     = $clog2(SLOTS);
  localparam int unsigned ID_W       = 8;
  localparam int unsigned NUM_IDS    = 1 << ID_W;
  localparam int unsigned ADDR_W     = 64;

  // The free-slot scan looks at one group of valid bits per cycle.
  localparam int unsigned GROUP_SIZE = 8;
  localparam int unsigned GROUP_W    = $clog2(GROUP_SIZE);
  localparam int unsigned NUM_GROUPS = SLOTS / GROUP_SIZE;
  localparam int unsigned GIDX_W     = $clog2(NUM_GROUPS);

  // The try counter must hold SLOTS itself.
  localparam int unsigned TRY_W      = $clog2(SLOTS + 1);

  // Request operation codes.
  localparam logic FUNC_ASSIGN = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // First value of the candidate counter after reset.
  localparam logic [ID_W-1:0] CAND_RESET = ID_W'(1);

  // Status reported by the free-slot scanner.
  typedef struct packed {
    logic              done;
    logic              full;
    logic [SLOT_W-1:0] slot;
  } scan_status_t;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_FIND   = 4'b0010,
    ST_DRAW   = 4'b0100,
    ST_REMOVE = 4'b1000
  } state_e;

endpackage

>>> design/rida_if.sv
// ----------------------------------------------------------------------------
// rida_req_if / rida_rsp_if
// Request and response channels of the region id allocator.
// ----------------------------------------------------------------------------
interface rida_req_if
  import rida_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] owner_addr;
  logic [ID_W-1:0]   target_id;

  modport source (output valid, func, owner_addr, target_id, input ready);
  modport sink   (input valid, func, owner_addr, target_id, output ready);
endinterface

interface rida_rsp_if
  import rida_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            ok;
  logic [ID_W-1:0] assigned_id;

  modport source (output valid, ok, assigned_id, input ready);
  modport sink   (input valid, ok, assigned_id, output ready);
endinterface

>>> design/rida_ram.sv
// ----------------------------------------------------------------------------
// rida_ram
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module rida_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rida_scan.sv
// ----------------------------------------------------------------------------
// rida_scan
// Finds the lowest free slot, one group of valid bits per cycle.
// ----------------------------------------------------------------------------
module rida_scan
  import rida_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SLOTS-1:0] slot_valid_i,
  output scan_status_t     status_o
);

  logic                  busy_q, busy_d;
  logic [GIDX_W-1:0]     group_q, group_d;
  logic [GROUP_SIZE-1:0] free_bits;
  logic [GROUP_W-1:0]    low_free;
  logic                  any_free;
  logic                  last_group;

  assign free_bits  = ~slot_valid_i[group_q*GROUP_SIZE +: GROUP_SIZE];
  assign any_free   = |free_bits;
  assign last_group = (group_q == GIDX_W'(NUM_GROUPS - 1));

  // Lowest zero within the current group.
  always_comb begin
    low_free = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        low_free = GROUP_W'(i);
      end
    end
  end

  always_comb begin
    busy_d          = busy_q;
    group_d         = group_q;
    status_o.done   = 1'b0;
    status_o.full   = 1'b0;
    status_o.slot   = {group_q, low_free};
    if (start_i) begin
      busy_d  = 1'b1;
      group_d = '0;
    end else if (busy_q) begin
      if (any_free || last_group) begin
        status_o.done = 1'b1;
        status_o.full = ~any_free;
        busy_d        = 1'b0;
      end else begin
        group_d = group_q + GIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      group_q <= '0;
    end else begin
      busy_q  <= busy_d;
      group_q <= group_d;
    end
  end

endmodule

>>> design/region_id_allocator_top.sv
// ----------------------------------------------------------------------------
// region_id_allocator_top
// Hands out unique 8-bit region ids to table slots and takes them back.
// ----------------------------------------------------------------------------
// Assign: the accepting cycle, the free-slot scan (eight valid bits per cycle)
//   and up to 65 candidate draws, one per cycle while the output has room.
// Remove: uses the registered id-to-slot map read issued with the request.
// One request is in flight at a time; a finished response waits in the output
//   register while the next request is taken. Reset is asynchronous, active
//   low, empties the table and sets the candidate counter to one; no sweep.
// ----------------------------------------------------------------------------
module region_id_allocator_top
  import rida_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rida_req_if.sink   req_i,
  rida_rsp_if.source rsp_o
);

  // --------------------------------------------------------------------------
  // State overview.
  //   slot_valid_q : one valid bit per slot.
  //   id_used_q    : one bit per id, set while some valid slot holds that id.
  //                  Assign never hands out an id already in use, so each id
  //                  lives in at most one slot, and this bit answers the
  //                  "is this candidate taken" question combinationally.
  //   map RAM      : id -> slot it lives in, read by remove.
  //   owner RAM    : slot -> owner address, written on a successful assign.
  // --------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [SLOTS-1:0]    slot_valid_q, slot_valid_d;
  logic [NUM_IDS-1:0]  id_used_q, id_used_d;
  logic [ID_W-1:0]     cand_cnt_q, cand_cnt_d;
  logic [TRY_W-1:0]    tries_q, tries_d;
  logic                full_q, full_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [ADDR_W-1:0]   owner_q;
  logic [ID_W-1:0]     rid_q;

  logic                rsp_valid_q, rsp_valid_d;
  logic                rsp_ok_q, rsp_ok_d;
  logic [ID_W-1:0]     rsp_id_q, rsp_id_d;

  logic                req_xfer;
  logic                out_free;
  logic                scan_start;
  scan_status_t        scan_status;

  logic [ID_W-1:0]     cand;
  logic [ID_W-1:0]     cand_next;
  logic                cand_taken;

  logic                map_we;
  logic [SLOT_W-1:0]   map_rdata;
  logic                owner_we;

  // Requests are taken only when the controller has nothing in flight.
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid & req_i.ready;

  // The output register can take a new response when it is empty or when its
  // current content transfers in this cycle.
  assign out_free = ~rsp_valid_q | rsp_o.ready;

  assign scan_start = req_xfer & (req_i.func == FUNC_ASSIGN);

  // A drawn zero is thrown away and the following value is drawn in the same
  // try, so the counter can step by two in a single draw.
  assign cand       = (cand_cnt_q == '0) ? ID_W'(1) : cand_cnt_q;
  assign cand_next  = cand + ID_W'(1);
  assign cand_taken = id_used_q[cand];

  rida_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (scan_start),
    .slot_valid_i (slot_valid_q),
    .status_o     (scan_status)
  );

  // Id-to-slot map. Read whenever a request is taken; written when an assign
  // succeeds. The two never overlap because one request is handled at a time.
  rida_ram #(
    .DEPTH (NUM_IDS),
    .WIDTH (SLOT_W)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (cand),
    .wdata_i (slot_q),
    .re_i    (req_xfer),
    .raddr_i (req_i.target_id),
    .rdata_o (map_rdata)
  );

  // Owner addresses are stored only; the request path never reads them back.
  rida_ram #(
    .DEPTH (SLOTS),
    .WIDTH (ADDR_W)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (owner_we),
    .waddr_i (slot_q),
    .wdata_i (owner_q),
    .re_i    (1'b0),
    .raddr_i (slot_q),
    .rdata_o ()
  );

  // --------------------------------------------------------------------------
  // Controller.
  // --------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    slot_valid_d = slot_valid_q;
    id_used_d    = id_used_q;
    cand_cnt_d   = cand_cnt_q;
    tries_d      = tries_q;
    full_d       = full_q;
    slot_d       = slot_q;
    rsp_valid_d  = rsp_valid_q & ~rsp_o.ready;
    rsp_ok_d     = rsp_ok_q;
    rsp_id_d     = rsp_id_q;
    map_we       = 1'b0;
    owner_we     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          tries_d = '0;
          if (req_i.func == FUNC_ASSIGN) begin
            state_d = ST_FIND;
          end else begin
            state_d = ST_REMOVE;
          end
        end
      end

      ST_FIND: begin
        // Latch the scan result; a full table is reported from ST_DRAW
        // without moving the counter.
        if (scan_status.done) begin
          full_d  = scan_status.full;
          slot_d  = scan_status.slot;
          state_d = ST_DRAW;
        end
      end

      ST_DRAW: begin
        // Each step waits for room in the output register, so a draw is
        // never made without its outcome being recorded.
        if (out_free) begin
          if (full_q) begin
            rsp_valid_d = 1'b1;
            rsp_ok_d    = 1'b0;
            rsp_id_d    = '0;
            state_d     = ST_IDLE;
          end else begin
            cand_cnt_d = cand_next;
            if (tries_q == TRY_W'(SLOTS)) begin
              // This draw was one more than allowed; it still counts.
              rsp_valid_d = 1'b1;
              rsp_ok_d    = 1'b0;
              rsp_id_d    = '0;
              state_d     = ST_IDLE;
            end else if (!cand_taken) begin
              slot_valid_d[slot_q] = 1'b1;
              id_used_d[cand]      = 1'b1;
              map_we               = 1'b1;
              owner_we             = 1'b1;
              rsp_valid_d          = 1'b1;
              rsp_ok_d             = 1'b1;
              rsp_id_d             = cand;
              state_d              = ST_IDLE;
            end else begin
              tries_d = tries_q + TRY_W'(1);
            end
          end
        end
      end

      ST_REMOVE: begin
        // The map read issued with the request is valid now. An id that is
        // not in use (id zero among them) leaves the table untouched.
        if (out_free) begin
          if (id_used_q[rid_q]) begin
            slot_valid_d[map_rdata] = 1'b0;
            id_used_d[rid_q]        = 1'b0;
          end
          rsp_valid_d = 1'b1;
          rsp_ok_d    = id_used_q[rid_q];
          rsp_id_d    = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      slot_valid_q <= '0;
      id_used_q    <= '0;
      cand_cnt_q   <= CAND_RESET;
      tries_q      <= '0;
      full_q       <= 1'b0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_valid_q <= slot_valid_d;
      id_used_q    <= id_used_d;
      cand_cnt_q   <= cand_cnt_d;
      tries_q      <= tries_d;
      full_q       <= full_d;
      rsp_valid_q  <= rsp_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    slot_q   <= slot_d;
    rsp_ok_q <= rsp_ok_d;
    rsp_id_q <= rsp_id_d;
    if (req_xfer) begin
      owner_q <= req_i.owner_addr;
      rid_q   <= req_i.target_id;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.ok          = rsp_ok_q;
  assign rsp_o.assigned_id = rsp_id_q;

endmodule

>>> tb/sv/region_id_allocator_top_test.sv
// ----------------------------------------------------------------------------
// region_id_allocator_top_test
// Self-checking test of the region id allocator. Requests are driven through
// the request channel, a predictor of the slot table and the candidate
// counter works out the grant of each accepted transfer, and every response
// transfer is compared field by field with the oldest outstanding grant.
// ----------------------------------------------------------------------------
module region_id_allocator_top_test;
  import rida_pkg::*;

  // The run is ended by the cycle counter if the block stops responding.
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned MAX_GAP     = 30;
  localparam int unsigned NUM_DIR     = 19;

  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] owner;
    logic [ID_W-1:0]   rid;
  } id_req_t;

  typedef struct {
    bit            ok;
    bit [ID_W-1:0] id;
  } grant_t;

  // One row of the directed table. Where fixed is set, the grant is typed in
  // here; otherwise it comes from the predictor.
  typedef struct {
    logic              func;
    logic [ADDR_W-1:0] owner;
    logic [ID_W-1:0]   rid;
    bit                fixed;
    bit                ok;
    bit [ID_W-1:0]     id;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rida_req_if req_if ();
  rida_rsp_if rsp_if ();

  region_id_allocator_top u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Predictor state: which slots hold an id, and which id. The owner address
  // is written on assign but never read back, so it is not kept here.
  bit              slot_live [SLOTS];
  bit [ID_W-1:0]   slot_rid  [SLOTS];
  bit [ID_W-1:0]   cand_ctr;
  int unsigned     wrap_count;
  bit              full_seen;

  // Grants predicted for accepted requests, oldest first.
  grant_t          grant_q [$];
  int unsigned     mismatch_count;
  int unsigned     cycle_count;

  // Idle rates of both sides, in percent, and the receiver's long hold-off.
  int unsigned     snd_idle_pct;
  int unsigned     rsp_idle_pct;
  int unsigned     rsp_hold_left;

  // Random stimulus mode: fill the table toward full, or drain it.
  bit              fill_mode;
  int unsigned     drain_floor;

  // Directed part, starting from an empty table with the counter at one.
  // The first three assigns take ids 1, 2 and 3. Removing 2 frees slot 1,
  // so the next assign lands there with id 4. Ids 0, 255 and 0x7F are
  // never held, so removing them fails. The owner address and the ignored
  // region id of assigns walk their extremes.
  dir_row_t dir_rows [NUM_DIR] = '{
    '{FUNC_ASSIGN, 64'h0,                   8'h00, 1'b1, 1'b1, 8'd1},
    '{FUNC_ASSIGN, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1, 8'd2},
    '{FUNC_ASSIGN, 64'h5555_5555_5555_5555, 8'h00, 1'b1, 1'b1, 8'd3},
    '{FUNC_REMOVE, 64'h0,                   8'd2,  1'b1, 1'b1, 8'd0},
    '{FUNC_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd2,  1'b1, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'h00, 1'b1, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'hFF, 1'b1, 1'b0, 8'd0},
    '{FUNC_ASSIGN, 64'hAAAA_AAAA_AAAA_AAAA, 8'h80, 1'b1, 1'b1, 8'd4},
    '{FUNC_ASSIGN, 64'h8000_0000_0000_0001, 8'h55, 1'b1, 1'b1, 8'd5},
    '{FUNC_REMOVE, 64'h0,                   8'd1,  1'b1, 1'b1, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'd5,  1'b1, 1'b1, 8'd0},
    '{FUNC_ASSIGN, 64'h0123_4567_89AB_CDEF, 8'hAA, 1'b0, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'h7F, 1'b1, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'd3,  1'b0, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'd4,  1'b0, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'd6,  1'b0, 1'b0, 8'd0},
    '{FUNC_ASSIGN, 64'hFEDC_BA98_7654_3210, 8'h01, 1'b0, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'h80, 1'b1, 1'b0, 8'd0},
    '{FUNC_REMOVE, 64'h0,                   8'd7,  1'b0, 1'b0, 8'd0}
  };

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Lowest live slot holding the id, or -1.
  function automatic int holder_of(input bit [ID_W-1:0] id);
    int hit;
    hit = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_live[i] && slot_rid[i] == id) begin
        hit = i;
      end
    end
    return hit;
  endfunction

  // Takes the counter value and advances it; the counter wraps from 255 to 0.
  function automatic bit [ID_W-1:0] draw_candidate();
    bit [ID_W-1:0] v;
    v        = cand_ctr;
    cand_ctr = cand_ctr + 1'b1;
    if (cand_ctr == '0) begin
      wrap_count++;
    end
    return v;
  endfunction

  function automatic grant_t predict_grant(input id_req_t r);
    grant_t        g;
    int            slot;
    int unsigned   tries;
    bit [ID_W-1:0] cand;
    g = '{ok: 1'b0, id: '0};
    if (r.func == FUNC_REMOVE) begin
      slot = holder_of(r.rid);
      if (slot >= 0) begin
        slot_live[slot] = 1'b0;
        slot_rid[slot]  = '0;
        g.ok            = 1'b1;
      end
    end else begin
      slot = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot < 0 && !slot_live[i]) begin
          slot = i;
        end
      end
      if (slot < 0) begin
        // Table full: the counter stays where it is.
        full_seen = 1'b1;
      end else begin
        // A drawn 0 is thrown away within the same try. A search that runs
        // past SLOTS tries fails but keeps every counter advance it made.
        tries = 0;
        do begin
          cand = draw_candidate();
          if (cand == '0) begin
            cand = draw_candidate();
          end
          tries++;
        end while (tries <= SLOTS && holder_of(cand) >= 0);
        if (tries <= SLOTS) begin
          slot_live[slot] = 1'b1;
          slot_rid[slot]  = cand;
          g.ok            = 1'b1;
          g.id            = cand;
        end
      end
    end
    return g;
  endfunction

  function automatic int unsigned live_slots();
    int unsigned n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      n += slot_live[i];
    end
    return n;
  endfunction

  // Picks one of the ids currently held, uniformly. Needs at least one.
  function automatic bit [ID_W-1:0] pick_live_id(input int unsigned live);
    int            k;
    bit [ID_W-1:0] id;
    k  = $urandom_range(live - 1);
    id = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i]) begin
        if (k == 0) begin
          id = slot_rid[i];
        end
        k--;
      end
    end
    return id;
  endfunction

  // --------------------------------------------------------------------------
  // Random stimulus
  // --------------------------------------------------------------------------

  // Fill mode is mostly assigns, so the table reaches full and assigns
  // against a full table get tried. Drain mode is mostly removes of held
  // ids, down to a random floor. Both keep some removes of arbitrary ids,
  // which mostly miss.
  function automatic id_req_t next_random_request();
    id_req_t     r;
    int unsigned live;
    int unsigned roll;
    live = live_slots();
    if (fill_mode && live == SLOTS && $urandom_range(2) == 0) begin
      fill_mode = 1'b0;
    end else if (!fill_mode && live <= drain_floor) begin
      fill_mode   = 1'b1;
      drain_floor = $urandom_range(40);
    end
    roll    = $urandom_range(99);
    r.owner = {$urandom, $urandom};
    r.rid   = ID_W'($urandom_range(NUM_IDS - 1));
    if (fill_mode ? roll < 80 : roll < 15) begin
      r.func = FUNC_ASSIGN;
    end else if (live > 0 && (fill_mode ? roll < 92 : roll < 90)) begin
      r.func = FUNC_REMOVE;
      r.rid  = pick_live_id(live);
    end else begin
      r.func = FUNC_REMOVE;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offers one request and returns at the edge where it is transferred. The
  // grant is queued at that edge: typed in for fixed directed rows, from the
  // predictor otherwise. The predictor runs either way to keep its state.
  task automatic push_request(input id_req_t r, input bit fixed, input grant_t fixed_g);
    int unsigned gap;
    grant_t      g;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= r.func;
    req_if.owner_addr <= r.owner;
    req_if.target_id  <= r.rid;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    g = predict_grant(r);
    grant_q.push_back(fixed ? fixed_g : g);
  endtask

  // Stops offering and waits until every outstanding grant has come back.
  task automatic drain_grants();
    req_if.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and cycle counter
  // --------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
        $display("[%0t] timeout after %0d cycles, %0d grants outstanding",
                 $time, cycle_count, grant_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Response side: drives ready and checks every response transfer. Values
  // are sampled right after the edge, before any nonblocking update lands,
  // so they are the ones the edge saw.
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    $display("[%0t] error: %s, got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  initial begin
    grant_t g;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (grant_q.size() == 0) begin
          report_mismatch("response with no request outstanding", rsp_if.assigned_id, 0);
        end else begin
          g = grant_q.pop_front();
          if (rsp_if.ok !== g.ok) begin
            report_mismatch("ok", rsp_if.ok, g.ok);
          end
          if (rsp_if.assigned_id !== g.id) begin
            report_mismatch("assigned_id", rsp_if.assigned_id, g.id);
          end
        end
      end
      // A long hold-off asked for by the request side overrides random idling.
      if (rsp_hold_left > 0) begin
        rsp_hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    id_req_t r;
    grant_t  fg;
    int unsigned n;

    // Every input is known from time zero.
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.func       = FUNC_ASSIGN;
    req_if.owner_addr = '0;
    req_if.target_id  = '0;
    mismatch_count    = 0;
    rsp_hold_left     = 0;
    snd_idle_pct      = 28;
    rsp_idle_pct      = 85;
    fill_mode         = 1'b1;
    drain_floor       = 0;
    wrap_count        = 0;
    full_seen         = 1'b0;
    cand_ctr          = CAND_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i] = 1'b0;
      slot_rid[i]  = '0;
    end

    // Reset is applied once.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, with the sender idling 28 percent and the receiver 85.
    for (int i = 0; i < NUM_DIR; i++) begin
      r  = '{func: dir_rows[i].func, owner: dir_rows[i].owner, rid: dir_rows[i].rid};
      fg = '{ok: dir_rows[i].ok, id: dir_rows[i].id};
      push_request(r, dir_rows[i].fixed, fg);
    end

    // Random part in three idling phases. The table full case and the
    // counter wrap need long well-formed runs, so they are reached here;
    // the last phase goes on until both have happened. Between phases the
    // sender pauses until every grant has come back.
    for (int phase = 0; phase < 3; phase++) begin
      drain_grants();
      case (phase)
        0: begin
          snd_idle_pct = 28;
          rsp_idle_pct = 85;
        end
        1: begin
          snd_idle_pct = 85;
          rsp_idle_pct = 28;
        end
        default: begin
          snd_idle_pct = 0;
          rsp_idle_pct = 0;
          // The receiver holds off while requests keep coming, so the
          // output register fills and the block stalls its input.
          rsp_hold_left = LONG_HOLD;
        end
      endcase
      n = 0;
      while (n < PHASE_ITEMS || (phase == 2 && (wrap_count == 0 || !full_seen))) begin
        push_request(next_random_request(), 1'b0, '{ok: 1'b0, id: '0});
        n++;
      end
    end

    // Wait for the last grants, then give the block time to show anything
    // it should not send.
    drain_grants();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
